FILE: rtl/ctzk_pkg.sv
// ----------------------------------------------------------------------------
// ctzk_pkg
// Shared types and constants for the closest-to-zero top-k selection block.
// ----------------------------------------------------------------------------
package ctzk_pkg;

	// Item command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_DUMP = 1'b1;

	// Width of a saturated energy magnitude
	localparam int unsigned MAG_W = 31;

	// Input item: signed Q8.24 energy, unsigned Q0.32 linewidth
	typedef struct packed {
		logic               command;
		logic signed [31:0] energy;
		logic        [31:0] linewidth;
	} in_t;

	// Result item
	typedef struct packed {
		logic               entry_valid;
		logic signed [31:0] held_energy;
		logic        [31:0] held_linewidth;
		logic               last;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic insert;
		logic emit_entry;
		logic emit_empty;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic dump_last;
	} dp_status_t;

endpackage

FILE: rtl/closest_to_zero_top_k_core.sv
// ----------------------------------------------------------------------------
// closest_to_zero_top_k_core
// Keeps the CAPACITY entries of smallest energy magnitude in ascending order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. For an add item, the
// accept cycle latches the item and its magnitude, and the insert step then
// compares it against every cell of the row at once and shifts it into
// place, with busy high. A dump item of N held entries keeps busy high after
// the accept until every entry has been presented, one result per entry, as
// the row rotates by one cell per cycle to present each entry at its head;
// the row is back in its original order when the dump ends. A dump of an
// empty row gives one result, with entry_valid low, in the cycle after the
// accept and keeps busy low. Results appear on result with result_strobe
// high for exactly one cycle, in the cycle after the step that produced them;
// the receiver must take every result as it comes.
// ----------------------------------------------------------------------------
module closest_to_zero_top_k_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ctzk_pkg::in_t    item,
	output logic             result_strobe,
	output ctzk_pkg::out_t   result
);

	ctzk_pkg::ctrl_cmd_t  cmd;
	ctzk_pkg::dp_status_t status;

	// Sequence items
	ctzk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (item.command),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	// Hold the sorted row and produce results
	ctzk_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.status        (status),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

FILE: rtl/ctzk_ctrl.sv
// ----------------------------------------------------------------------------
// ctzk_ctrl
// Controller: sequences item acceptance, the insert cycle and dump output.
// ----------------------------------------------------------------------------
module ctzk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  command,
	input  ctzk_pkg::dp_status_t  status,
	output ctzk_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_DUMP   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (command == ctzk_pkg::CMD_ADD) begin
						state_d = ST_INSERT;
					end else if (status.empty) begin
						cmd.emit_empty = 1'b1;
					end else begin
						state_d = ST_DUMP;
					end
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_DUMP: begin
				cmd.emit_entry = 1'b1;
				if (status.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An insert always returns to idle
	a_insert_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (state_q == ST_IDLE))
		else $error("insert did not finish in one cycle");

	// Only one output command per cycle
	a_emit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_entry && cmd.emit_empty))
		else $error("entry and empty results emitted together");

	// Empty dump never enters the dump state
	a_empty_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_empty |=> (state_q == ST_IDLE))
		else $error("empty dump left idle");

endmodule

FILE: rtl/ctzk_dp.sv
// ----------------------------------------------------------------------------
// ctzk_dp
// Datapath: sorted row of entry cells with parallel compare-and-shift insert,
// rotation for dump readout, and the result register.
// ----------------------------------------------------------------------------
module ctzk_dp #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctzk_pkg::in_t         item,
	input  ctzk_pkg::ctrl_cmd_t   cmd,
	output ctzk_pkg::dp_status_t  status,
	output logic                  result_strobe,
	output ctzk_pkg::out_t        result
);

	localparam int unsigned CW    = $clog2(CAPACITY + 1);
	localparam int unsigned MAG_W = ctzk_pkg::MAG_W;

	// Saturated absolute value of a signed energy
	function automatic logic [MAG_W-1:0] mag_of(input logic [31:0] e);
		logic [31:0] neg;
		neg = ~e + 32'd1;
		if (e == 32'h8000_0000) begin
			mag_of = {MAG_W{1'b1}};
		end else if (e[31]) begin
			mag_of = neg[MAG_W-1:0];
		end else begin
			mag_of = e[MAG_W-1:0];
		end
	endfunction

	logic [31:0]      energy_q [CAPACITY];
	logic [31:0]      lw_q     [CAPACITY];
	logic [MAG_W-1:0] mag_q    [CAPACITY];

	ctzk_pkg::in_t    in_q;
	logic [MAG_W-1:0] in_mag_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    dump_q;
	logic [CW-1:0]    fill_last;
	logic [CW-1:0]    cnt_eff;
	logic             full;
	logic             write_en;
	logic             ins_hit [CAPACITY];
	logic             result_strobe_q;
	ctzk_pkg::out_t   result_q;

	assign full      = (fill_q == CW'(CAPACITY));
	assign cnt_eff   = full ? CW'(CAPACITY - 1) : fill_q;
	assign fill_last = fill_q - CW'(1);
	assign write_en  = cmd.insert && (!full || (in_mag_q < mag_q[CAPACITY-1]));

	assign status.empty     = (fill_q == '0);
	assign status.dump_last = (dump_q == fill_last);

	// Latch the accepted item and its magnitude
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q     <= item;
			in_mag_q <= mag_of(item.energy);
		end
	end

	// Fill count and dump position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			dump_q <= '0;
		end else begin
			if (cmd.insert && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.load) begin
				dump_q <= '0;
			end else if (cmd.emit_entry) begin
				dump_q <= dump_q + CW'(1);
			end
		end
	end

	// Per-cell insert position: new item lands at or before this cell
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cmp
		always_comb begin
			if (CW'(k) < cnt_eff) begin
				ins_hit[k] = (mag_q[k] > in_mag_q);
			end else begin
				ins_hit[k] = (CW'(k) == cnt_eff);
			end
		end
	end

	// Cell update: shift or take the new item on insert, rotate on dump
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [31:0]      nxt_e;
		logic [31:0]      nxt_lw;
		logic [MAG_W-1:0] nxt_mag;
		logic             prev_hit;

		if (k == 0) begin : g_first
			assign prev_hit = 1'b0;
		end else begin : g_rest
			assign prev_hit = ins_hit[k-1];
		end

		if (k == CAPACITY - 1) begin : g_tail
			assign nxt_e   = energy_q[0];
			assign nxt_lw  = lw_q[0];
			assign nxt_mag = mag_q[0];
		end else begin : g_body
			assign nxt_e   = (CW'(k) == fill_last) ? energy_q[0] : energy_q[k+1];
			assign nxt_lw  = (CW'(k) == fill_last) ? lw_q[0]     : lw_q[k+1];
			assign nxt_mag = (CW'(k) == fill_last) ? mag_q[0]    : mag_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (write_en && ins_hit[k]) begin
				if (prev_hit) begin
					energy_q[k] <= energy_q[(k == 0) ? 0 : k-1];
					lw_q[k]     <= lw_q[(k == 0) ? 0 : k-1];
					mag_q[k]    <= mag_q[(k == 0) ? 0 : k-1];
				end else begin
					energy_q[k] <= in_q.energy;
					lw_q[k]     <= in_q.linewidth;
					mag_q[k]    <= in_mag_q;
				end
			end else if (cmd.emit_entry && (CW'(k) < fill_q)) begin
				energy_q[k] <= nxt_e;
				lw_q[k]     <= nxt_lw;
				mag_q[k]    <= nxt_mag;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= cmd.emit_entry || cmd.emit_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_entry) begin
			result_q.entry_valid    <= 1'b1;
			result_q.held_energy    <= energy_q[0];
			result_q.held_linewidth <= lw_q[0];
			result_q.last           <= status.dump_last;
		end else if (cmd.emit_empty) begin
			result_q.entry_valid    <= 1'b0;
			result_q.held_energy    <= '0;
			result_q.held_linewidth <= '0;
			result_q.last           <= 1'b1;
		end
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

	// Fill count never exceeds the row size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// Entries are only emitted from a non-empty row
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_entry |-> !status.empty)
		else $error("entry emitted from empty row");

	// Insert into a non-full row grows the count by one
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !full) |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("fill count did not grow on insert");

endmodule
